>>> hdl/trace_spike_fix_time_over_threshold_core_assert.svh
// assertion macros for the trace spike fix and time over threshold core
`ifndef TRACE_SPIKE_FIX_TIME_OVER_THRESHOLD_CORE_ASSERT_SVH
`define TRACE_SPIKE_FIX_TIME_OVER_THRESHOLD_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define TSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TSF_ASSERT_IMP(lbl, ante, cons, msg)

`define TSF_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/tsf_pkg.sv
// shared constants and types of the trace spike fix and time over threshold core
`timescale 1ns / 1ps

package tsf_pkg;

    localparam int SAMPLE_W     = 14;
    localparam int COUNT_W      = 16;
    localparam int BASELINE_LEN = 40;

    localparam int CNT_W     = $clog2(BASELINE_LEN + 1);
    localparam int SUM_W     = $clog2(BASELINE_LEN * ((1 << SAMPLE_W) - 1) + 1);
    localparam int LEN_LOG   = $clog2(BASELINE_LEN);
    localparam int DIV_SHIFT = SUM_W + LEN_LOG;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam longint unsigned RECIP_VAL =
        ((64'd1 << DIV_SHIFT) + BASELINE_LEN - 1) / BASELINE_LEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    localparam logic [SAMPLE_W-1:0] SPIKE_LEVEL_RST = SAMPLE_W'(16000);
    localparam logic [SAMPLE_W-1:0] OVER_MARGIN_RST = SAMPLE_W'(10);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_SPIKE_LEVEL = 1'b0;
    localparam logic REG_OVER_MARGIN = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                negative_pulse;
        logic                last;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] fixed;
        logic [CNT_W-1:0]    idx;
    } t_lane;

    typedef struct packed {
        t_lane a;
        t_lane b;
        logic  neg;
        logic  last;
        logic  short_trace;
    } t_evt;

    typedef struct packed {
        logic [COUNT_W-1:0]  over_count;
        logic [SAMPLE_W-1:0] baseline_level;
        logic                short_trace;
    } t_result;

endpackage

>>> hdl/tsf_smp_if.sv
// sample channel interface
`timescale 1ns / 1ps

interface tsf_smp_if;
    logic                         valid;
    logic                         ready;
    logic [tsf_pkg::SAMPLE_W-1:0] sample;
    logic                         negative_pulse;
    logic                         last;

    modport source (output valid, sample, negative_pulse, last, input ready);
    modport sink (input valid, sample, negative_pulse, last, output ready);
endinterface

>>> hdl/tsf_res_if.sv
// result channel interface
`timescale 1ns / 1ps

interface tsf_res_if;
    logic                         valid;
    logic                         ready;
    logic [tsf_pkg::COUNT_W-1:0]  over_count;
    logic [tsf_pkg::SAMPLE_W-1:0] baseline_level;
    logic                         short_trace;

    modport source (output valid, over_count, baseline_level, short_trace, input ready);
    modport sink (input valid, over_count, baseline_level, short_trace, output ready);
endinterface

>>> hdl/tsf_fix.sv
// input register and spike repair with one sample lookahead
`timescale 1ns / 1ps
`include "trace_spike_fix_time_over_threshold_core_assert.svh"

module tsf_fix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  tsf_pkg::t_item               i_item,
    input  logic [tsf_pkg::SAMPLE_W-1:0] i_spike_level,
    output tsf_pkg::t_evt                o_evt
);

    logic                         r_s0_valid;
    tsf_pkg::t_item               r_s0;
    logic                         r_held_v;
    logic [tsf_pkg::SAMPLE_W-1:0] r_held_raw;
    logic [tsf_pkg::SAMPLE_W-1:0] r_prev;
    logic [tsf_pkg::CNT_W-1:0]    r_cnt;
    tsf_pkg::t_evt                r_evt;

    logic                         w_has_a;
    logic                         w_has_b;
    logic [tsf_pkg::SAMPLE_W-1:0] w_pred_a;
    logic [tsf_pkg::SAMPLE_W:0]   w_mean_sum;
    logic [tsf_pkg::SAMPLE_W-1:0] w_fix_a;
    logic [tsf_pkg::SAMPLE_W-1:0] w_pred_b;
    logic [tsf_pkg::SAMPLE_W-1:0] w_fix_b;
    logic [tsf_pkg::CNT_W-1:0]    n_cnt;
    logic [tsf_pkg::CNT_W:0]      w_cnt_end;
    tsf_pkg::t_evt                n_evt;

    always_comb begin
        w_has_a    = r_s0_valid && r_held_v;
        w_has_b    = r_s0_valid && r_s0.last;
        // first sample borrows its successor as predecessor
        w_pred_a   = (r_cnt == '0) ? r_s0.sample : r_prev;
        w_mean_sum = {1'b0, w_pred_a} + {1'b0, r_s0.sample};
        if (r_held_raw > i_spike_level) begin
            if (r_s0.sample < i_spike_level) begin
                w_fix_a = w_mean_sum[tsf_pkg::SAMPLE_W:1];
            end else begin
                w_fix_a = w_pred_a;
            end
        end else begin
            w_fix_a = r_held_raw;
        end

        if (w_has_a && (r_cnt != tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN))) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end

        // last sample has no successor
        w_pred_b  = r_held_v ? w_fix_a : r_s0.sample;
        w_fix_b   = (r_s0.sample > i_spike_level) ? w_pred_b : r_s0.sample;
        w_cnt_end = {1'b0, n_cnt} + 1'b1;

        n_evt.a.valid     = w_has_a;
        n_evt.a.fixed     = w_fix_a;
        n_evt.a.idx       = r_cnt;
        n_evt.b.valid     = w_has_b;
        n_evt.b.fixed     = w_fix_b;
        n_evt.b.idx       = n_cnt;
        n_evt.neg         = r_s0.negative_pulse;
        n_evt.last        = w_has_b;
        n_evt.short_trace = w_has_b &&
            (w_cnt_end < (tsf_pkg::CNT_W + 1)'(tsf_pkg::BASELINE_LEN));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_held_v   <= 1'b0;
            r_cnt      <= '0;
            r_prev     <= '0;
            r_evt      <= '0;
        end else if (i_en) begin
            r_s0_valid <= i_valid;
            r_evt      <= n_evt;
            if (r_s0_valid) begin
                if (r_s0.last) begin
                    r_held_v <= 1'b0;
                    r_cnt    <= '0;
                    r_prev   <= '0;
                end else begin
                    r_held_v <= 1'b1;
                    r_cnt    <= n_cnt;
                    if (w_has_a) begin
                        r_prev <= w_fix_a;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0 <= i_item;
            if (r_s0_valid && !r_s0.last) begin
                r_held_raw <= r_s0.sample;
            end
        end
    end

    assign o_evt = r_evt;

    `TSF_ASSERT_NEXT(a_trace_restart, i_en && r_s0_valid && r_s0.last, !r_held_v && r_cnt == '0, "trace state not cleared after last sample")
    `TSF_ASSERT_IMP(a_lanes_order, r_evt.b.valid && r_evt.a.valid, r_evt.b.idx != '0, "lookahead lane and final lane out of order")
    `TSF_ASSERT_IMP(a_cnt_bound, r_s0_valid, r_cnt <= tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN), "sample counter beyond the baseline window")

endmodule

>>> hdl/tsf_base.sv
// baseline window sum and reciprocal divide
`timescale 1ns / 1ps

module tsf_base (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  tsf_pkg::t_evt                i_evt,
    output tsf_pkg::t_evt                o_evt,
    output logic [tsf_pkg::SAMPLE_W-1:0] o_base
);

    logic [tsf_pkg::SUM_W-1:0]    r_sum;
    logic                         r_div_v;
    logic [tsf_pkg::SUM_W-1:0]    r_div_in;
    logic [tsf_pkg::SAMPLE_W-1:0] r_base;
    tsf_pkg::t_evt                r_s2;
    tsf_pkg::t_evt                r_s3;

    logic [tsf_pkg::SAMPLE_W-1:0] w_add_a;
    logic [tsf_pkg::SAMPLE_W-1:0] w_add_b;
    logic [tsf_pkg::SUM_W-1:0]    n_sum;
    logic                         w_win_end;
    logic [tsf_pkg::PROD_W-1:0]   w_prod;

    always_comb begin
        w_add_a = (i_evt.a.valid && i_evt.a.idx < tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN))
                  ? i_evt.a.fixed : '0;
        w_add_b = (i_evt.b.valid && i_evt.b.idx < tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN))
                  ? i_evt.b.fixed : '0;
        n_sum   = r_sum + tsf_pkg::SUM_W'(w_add_a) + tsf_pkg::SUM_W'(w_add_b);
        w_win_end =
            (i_evt.a.valid && i_evt.a.idx == tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN - 1)) ||
            (i_evt.b.valid && i_evt.b.idx == tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN - 1));
        w_prod  = tsf_pkg::PROD_W'(r_div_in) * tsf_pkg::PROD_W'(tsf_pkg::RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_div_v <= 1'b0;
            r_s2    <= '0;
            r_s3    <= '0;
        end else if (i_en) begin
            r_sum   <= i_evt.last ? '0 : n_sum;
            r_div_v <= w_win_end;
            r_s2    <= i_evt;
            r_s3    <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_win_end) begin
                r_div_in <= n_sum;
            end
            if (r_div_v) begin
                r_base <= w_prod[tsf_pkg::DIV_SHIFT +: tsf_pkg::SAMPLE_W];
            end
        end
    end

    assign o_evt  = r_s3;
    assign o_base = r_base;

endmodule

>>> hdl/tsf_count.sv
// over threshold tally, result register and pipeline stall
`timescale 1ns / 1ps
`include "trace_spike_fix_time_over_threshold_core_assert.svh"

module tsf_count (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tsf_pkg::t_evt                i_evt,
    input  logic [tsf_pkg::SAMPLE_W-1:0] i_base,
    input  logic [tsf_pkg::SAMPLE_W-1:0] i_margin,
    input  logic                         i_ready,
    output logic                         o_en,
    output logic                         o_valid,
    output tsf_pkg::t_result             o_res
);

    logic [tsf_pkg::COUNT_W-1:0] r_tally;
    logic                        r_out_valid;
    tsf_pkg::t_result            r_out;

    logic                        w_hit_a;
    logic                        w_hit_b;
    logic [tsf_pkg::COUNT_W:0]   w_tally_sum;
    logic [tsf_pkg::COUNT_W-1:0] n_tally;
    tsf_pkg::t_result            n_out;

    function automatic logic over_margin_chk(input logic [tsf_pkg::SAMPLE_W-1:0] fixed,
                                             input logic [tsf_pkg::SAMPLE_W-1:0] base,
                                             input logic [tsf_pkg::SAMPLE_W-1:0] margin,
                                             input logic                         neg);
        logic [tsf_pkg::SAMPLE_W:0] fix_m;
        logic [tsf_pkg::SAMPLE_W:0] base_m;
        fix_m  = {1'b0, fixed} + {1'b0, margin};
        base_m = {1'b0, base} + {1'b0, margin};
        if (neg) begin
            return {1'b0, base} > fix_m;
        end else begin
            return {1'b0, fixed} > base_m;
        end
    endfunction

    always_comb begin
        // stall only when a result would land on a result not yet taken
        o_en    = !(i_evt.last && r_out_valid && !i_ready);
        w_hit_a = i_evt.a.valid && (i_evt.a.idx == tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN)) &&
                  over_margin_chk(i_evt.a.fixed, i_base, i_margin, i_evt.neg);
        w_hit_b = i_evt.b.valid && (i_evt.b.idx == tsf_pkg::CNT_W'(tsf_pkg::BASELINE_LEN)) &&
                  over_margin_chk(i_evt.b.fixed, i_base, i_margin, i_evt.neg);
        w_tally_sum = {1'b0, r_tally} + (tsf_pkg::COUNT_W + 1)'(w_hit_a)
                      + (tsf_pkg::COUNT_W + 1)'(w_hit_b);
        n_tally = w_tally_sum[tsf_pkg::COUNT_W] ? '1 : w_tally_sum[tsf_pkg::COUNT_W-1:0];
        if (i_evt.short_trace) begin
            n_out.over_count     = '0;
            n_out.baseline_level = '0;
            n_out.short_trace    = 1'b1;
        end else begin
            n_out.over_count     = n_tally;
            n_out.baseline_level = i_base;
            n_out.short_trace    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_en) begin
                r_tally <= i_evt.last ? '0 : n_tally;
            end
            if (o_en && i_evt.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en && i_evt.last) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    `TSF_ASSERT_IMP(a_short_clean, r_out_valid && r_out.short_trace, r_out.over_count == '0 && r_out.baseline_level == '0, "short trace result carries count or baseline")
    `TSF_ASSERT_NEXT(a_tally_clear, o_en && i_evt.last, r_tally == '0, "tally not cleared after a result")
    `TSF_ASSERT_IMP(a_load_on_last, $rose(r_out_valid), $past(i_evt.last), "result appeared without a last sample")

endmodule

>>> hdl/trace_spike_fix_time_over_threshold_core.sv
// top level of the trace spike fix and time over threshold core
`timescale 1ns / 1ps

// One sample is accepted per clock; the result of a trace reaches the output register
// through these stages once its last sample is accepted (the input register takes the sample
// at the accepting edge, then repair stage, window sum stage, reciprocal multiply stage,
// tally stage). Intake stalls only when a result reaches the tally stage while the previous
// result still sits untaken in the output register, and ready is low during reset. The
// baseline divide is a single multiply by a fixed reciprocal, so it adds latency but never
// blocks. There is no clearing pass after reset. spike_level sits at byte address 0 and
// over_margin at byte address 4; write them only while no trace is in flight.

module trace_spike_fix_time_over_threshold_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tsf_smp_if.sink                        i_smp,
    tsf_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tsf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tsf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [tsf_pkg::SAMPLE_W-1:0] r_spike_level;
    logic [tsf_pkg::SAMPLE_W-1:0] r_over_margin;

    logic                         w_en;
    tsf_pkg::t_item               w_item;
    tsf_pkg::t_evt                w_evt1;
    tsf_pkg::t_evt                w_evt3;
    logic [tsf_pkg::SAMPLE_W-1:0] w_base;
    tsf_pkg::t_result             w_res;
    logic                         w_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spike_level <= tsf_pkg::SPIKE_LEVEL_RST;
            r_over_margin <= tsf_pkg::OVER_MARGIN_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                tsf_pkg::REG_SPIKE_LEVEL: r_spike_level <= pwdata[tsf_pkg::SAMPLE_W-1:0];
                tsf_pkg::REG_OVER_MARGIN: r_over_margin <= pwdata[tsf_pkg::SAMPLE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tsf_pkg::REG_SPIKE_LEVEL: prdata = tsf_pkg::APB_DATA_W'(r_spike_level);
            tsf_pkg::REG_OVER_MARGIN: prdata = tsf_pkg::APB_DATA_W'(r_over_margin);
        endcase
    end

    assign pready = 1'b1;

    assign w_item.sample         = i_smp.sample;
    assign w_item.negative_pulse = i_smp.negative_pulse;
    assign w_item.last           = i_smp.last;
    assign i_smp.ready           = w_en && i_rst_n;

    tsf_fix u_fix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_smp.valid),
        .i_item        (w_item),
        .i_spike_level (r_spike_level),
        .o_evt         (w_evt1)
    );

    tsf_base u_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_evt   (w_evt1),
        .o_evt   (w_evt3),
        .o_base  (w_base)
    );

    tsf_count u_count (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (w_evt3),
        .i_base   (w_base),
        .i_margin (r_over_margin),
        .i_ready  (o_res.ready),
        .o_en     (w_en),
        .o_valid  (w_res_valid),
        .o_res    (w_res)
    );

    assign o_res.valid          = w_res_valid;
    assign o_res.over_count     = w_res.over_count;
    assign o_res.baseline_level = w_res.baseline_level;
    assign o_res.short_trace    = w_res.short_trace;

endmodule
